@@ hw/rtl/lgm_pkg.sv @@
package lgm_pkg;

   localparam int ANGLE_BITS   = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int ITER_W       = $clog2(CORDIC_STEPS);
   localparam int TRIG_W       = 34;
   localparam int MUL_B_W      = 25;
   localparam int PROD_W       = TRIG_W + MUL_B_W;
   localparam int R_W          = PROD_W - 16;
   localparam int SUM_W        = 50;
   localparam int COORD_W      = SUM_W - 16;
   localparam int POSE_W       = 24;
   localparam int GAIN_W       = 24;
   localparam int SIZE_W       = 9;
   localparam int DIST_W       = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 24;

   localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
   localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 34'sd652032874;

   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POSE_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RANGE   = 3'd4;

   localparam logic [GAIN_W-1:0] RANGE_GAIN_RESET = 24'd19005;
   localparam logic [GAIN_W-1:0] POSE_GAIN_RESET  = 24'd1311;
   localparam logic [SIZE_W-1:0] GRID_SIZE_RESET  = 9'd256;
   localparam logic [DIST_W-1:0] MIN_RANGE_RESET  = 16'd5;

   localparam logic ACTION_MARK = 1'b0;
   localparam logic ACTION_READ = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_SKIPPED = 2'd1;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

   localparam int GRID_COLS_DEFAULT = 256;
   localparam int GRID_ROWS_DEFAULT = 256;

   typedef struct packed {
      logic [GAIN_W-1:0] range_gain;
      logic [GAIN_W-1:0] pose_gain;
   } lgm_gain_type;

   function automatic logic signed [TRIG_W-1:0] lgm_atan(input logic [ITER_W-1:0] idx);
      logic signed [TRIG_W-1:0] v;
      case (idx)
         4'd0:    v = 34'sd536870912;
         4'd1:    v = 34'sd316933406;
         4'd2:    v = 34'sd167458907;
         4'd3:    v = 34'sd85004756;
         4'd4:    v = 34'sd42667331;
         4'd5:    v = 34'sd21354465;
         4'd6:    v = 34'sd10680862;
         4'd7:    v = 34'sd5340245;
         4'd8:    v = 34'sd2670163;
         4'd9:    v = 34'sd1335087;
         4'd10:   v = 34'sd667544;
         4'd11:   v = 34'sd333772;
         4'd12:   v = 34'sd166886;
         4'd13:   v = 34'sd83443;
         4'd14:   v = 34'sd41722;
         4'd15:   v = 34'sd20861;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

@@ hw/rtl/lgm_ram.sv @@
module lgm_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/lgm_cordic.sv @@
module lgm_cordic import lgm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [31:0]              phase,
   output logic                     done,
   output logic signed [TRIG_W-1:0] cos_out,
   output logic signed [TRIG_W-1:0] sin_out
);

   typedef enum logic [1:0] {CS_IDLE, CS_ROTATE, CS_FIX} cordic_state_type;

   localparam logic signed [TRIG_W-1:0] QUARTER = 34'sd1073741824;
   localparam logic signed [TRIG_W-1:0] HALF    = 34'sd2147483648;

   cordic_state_type          state_ff;
   logic                      done_ff;
   logic signed [TRIG_W-1:0]  x_ff, y_ff, z_ff;
   logic [ITER_W-1:0]         iter_ff;
   logic                      neg_ff;

   logic signed [TRIG_W-1:0]  z_raw, z_in, dx, dy, atan_val;
   logic                      neg_in;

   always_comb begin
      z_raw = TRIG_W'($signed(phase));
      z_in = z_raw;
      neg_in = 1'b0;
      if (z_raw > QUARTER) begin
         z_in = z_raw - HALF;
         neg_in = 1'b1;
      end else if (z_raw < -QUARTER) begin
         z_in = z_raw + HALF;
         neg_in = 1'b1;
      end
   end

   assign dx = y_ff >>> iter_ff;
   assign dy = x_ff >>> iter_ff;
   assign atan_val = lgm_atan(iter_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            CS_IDLE: begin
               if (start) begin
                  x_ff <= CORDIC_X0;
                  y_ff <= '0;
                  z_ff <= z_in;
                  neg_ff <= neg_in;
                  iter_ff <= '0;
                  state_ff <= CS_ROTATE;
               end
            end
            CS_ROTATE: begin
               if (!z_ff[TRIG_W-1]) begin
                  x_ff <= x_ff - dx;
                  y_ff <= y_ff + dy;
                  z_ff <= z_ff - atan_val;
               end else begin
                  x_ff <= x_ff + dx;
                  y_ff <= y_ff - dy;
                  z_ff <= z_ff + atan_val;
               end
               iter_ff <= iter_ff + 1'b1;
               if (iter_ff == ITER_W'(CORDIC_STEPS - 1)) begin
                  state_ff <= CS_FIX;
               end
            end
            CS_FIX: begin
               if (neg_ff) begin
                  x_ff <= -x_ff;
                  y_ff <= -y_ff;
               end
               done_ff <= 1'b1;
               state_ff <= CS_IDLE;
            end
            default: state_ff <= CS_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign cos_out = x_ff;
   assign sin_out = y_ff;

endmodule

@@ hw/rtl/lgm_scale.sv @@
module lgm_scale import lgm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [TRIG_W-1:0]  cos_in,
   input  logic signed [TRIG_W-1:0]  sin_in,
   input  logic [DIST_W-1:0]         distance,
   input  logic signed [POSE_W-1:0]  pose_x,
   input  logic signed [POSE_W-1:0]  pose_y,
   input  lgm_gain_type              gains,
   output logic                      done,
   output logic signed [COORD_W-1:0] coord_x,
   output logic signed [COORD_W-1:0] coord_y
);

   typedef enum logic [2:0] {AS_IDLE, AS_MUL_P, AS_MUL_Q, AS_MUL_T, AS_SUM} scale_state_type;

   scale_state_type           state_ff;
   logic                      done_ff;
   logic                      y_axis_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [R_W-1:0]     r_ff;
   logic signed [COORD_W-1:0] coord_x_ff, coord_y_ff;

   logic signed [TRIG_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [SUM_W-1:0]   sum_in;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         AS_MUL_P: begin
            mul_a = y_axis_ff ? sin_in : cos_in;
            mul_b = $signed({{(MUL_B_W - DIST_W){1'b0}}, distance});
         end
         AS_MUL_Q: begin
            mul_a = $signed(prod_ff[TRIG_W+13:14]);
            mul_b = $signed({1'b0, gains.range_gain});
         end
         AS_MUL_T: begin
            mul_a = TRIG_W'(y_axis_ff ? pose_y : pose_x);
            mul_b = $signed({1'b0, gains.pose_gain});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign sum_in = SUM_W'(r_ff) + $signed(prod_ff[SUM_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AS_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            AS_IDLE: begin
               if (start) begin
                  y_axis_ff <= 1'b0;
                  state_ff <= AS_MUL_P;
               end
            end
            AS_MUL_P: begin
               prod_ff <= prod_in;
               state_ff <= AS_MUL_Q;
            end
            AS_MUL_Q: begin
               prod_ff <= prod_in;
               state_ff <= AS_MUL_T;
            end
            AS_MUL_T: begin
               r_ff <= prod_ff[PROD_W-1:16];
               prod_ff <= prod_in;
               state_ff <= AS_SUM;
            end
            AS_SUM: begin
               if (y_axis_ff) begin
                  coord_y_ff <= sum_in[SUM_W-1:16];
                  done_ff <= 1'b1;
                  state_ff <= AS_IDLE;
               end else begin
                  coord_x_ff <= sum_in[SUM_W-1:16];
                  y_axis_ff <= 1'b1;
                  state_ff <= AS_MUL_P;
               end
            end
            default: state_ff <= AS_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign coord_x = coord_x_ff;
   assign coord_y = coord_y_ff;

endmodule

@@ hw/rtl/lidar_occupancy_grid_marker.sv @@
// Marks lidar returns in an occupancy bit map and reads single cells back. A command is taken
// when start is high and busy is low; its one result appears on the rsp_ ports for exactly
// one cycle with rsp_valid high and cannot be held off, so the receiver must take it then.
// A mark command runs 16 CORDIC rotations and one sign fix, then three products of the shared
// multiplier and one sum for each axis, a registered hand-off into and out of the scaling unit,
// and the bound check and write. A read command checks the bound and then waits for
// the registered map memory read; one outside the grid answers without it. A mark whose
// range is below min_range answers in the cycle after it is taken and leaves busy low. After
// reset the map is cleared one cell per cycle over the whole grid, with busy high;
// register writes are taken during that pass.
module lidar_occupancy_grid_marker import lgm_pkg::*; #(
   parameter int GRID_COLS = GRID_COLS_DEFAULT,
   parameter int GRID_ROWS = GRID_ROWS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_action,
   input  logic [15:0]             req_scan_angle,
   input  logic [DIST_W-1:0]       req_scan_distance,
   input  logic signed [POSE_W-1:0] req_pose_x,
   input  logic signed [POSE_W-1:0] req_pose_y,
   input  logic [15:0]             req_pose_yaw,
   input  logic [7:0]              req_query_col,
   input  logic [7:0]              req_query_row,
   input  logic                    req_last_point,
   output logic                    rsp_valid,
   output logic                    rsp_marked,
   output logic [7:0]              rsp_cell_col,
   output logic [7:0]              rsp_cell_row,
   output logic [1:0]              rsp_status,
   output logic                    rsp_occupied,
   output logic                    rsp_last_of_scan,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int DEPTH = GRID_COLS * GRID_ROWS;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(GRID_COLS);
   localparam int RW = $clog2(GRID_ROWS);

   typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_CALC, ST_CHECK, ST_READ_WAIT} top_state_type;

   top_state_type             state_ff;
   logic [AW-1:0]             clr_cnt_ff;
   logic                      action_ff;
   logic                      last_ff;
   logic [DIST_W-1:0]         dist_ff;
   logic signed [POSE_W-1:0]  pose_x_ff, pose_y_ff;
   logic signed [COORD_W-1:0] col_ff, row_ff;

   logic                      rsp_valid_ff, rsp_marked_ff, rsp_occupied_ff, rsp_last_ff;
   logic [7:0]                rsp_col_ff, rsp_row_ff;
   logic [1:0]                rsp_status_ff;

   logic [GAIN_W-1:0]         range_gain_ff, pose_gain_ff;
   logic [SIZE_W-1:0]         grid_width_ff, grid_height_ff;
   logic [DIST_W-1:0]         min_range_ff;

   logic                      accept, cordic_start, cordic_done, scale_done;
   logic [15:0]               angle_sum;
   logic [31:0]               phase;
   logic signed [TRIG_W-1:0]  cos_val, sin_val;
   logic signed [COORD_W-1:0] coord_x, coord_y;
   lgm_gain_type              gains;
   logic [COORD_W-1:0]        cols_eff, rows_eff;
   logic                      in_grid;
   logic [AW-1:0]             cell_addr, ram_addr;
   logic                      ram_we, ram_wdata, ram_rdata;

   assign accept = start && !busy;
   assign cordic_start = accept && req_action == ACTION_MARK &&
                         req_scan_distance >= min_range_ff;
   assign angle_sum = req_scan_angle + req_pose_yaw;
   assign phase = {angle_sum, 16'd0} & PHASE_MASK;
   assign gains = '{range_gain: range_gain_ff, pose_gain: pose_gain_ff};

   assign cols_eff = (COORD_W'(grid_width_ff) < COORD_W'(GRID_COLS)) ?
                     COORD_W'(grid_width_ff) : COORD_W'(GRID_COLS);
   assign rows_eff = (COORD_W'(grid_height_ff) < COORD_W'(GRID_ROWS)) ?
                     COORD_W'(grid_height_ff) : COORD_W'(GRID_ROWS);
   assign in_grid = !col_ff[COORD_W-1] && !row_ff[COORD_W-1] &&
                    ($unsigned(col_ff) < cols_eff) && ($unsigned(row_ff) < rows_eff);
   assign cell_addr = AW'(row_ff[RW-1:0]) * AW'(GRID_COLS) + AW'(col_ff[CW-1:0]);

   assign ram_addr = (state_ff == ST_CLEAR) ? clr_cnt_ff : cell_addr;
   assign ram_we = (state_ff == ST_CLEAR) ||
                   (state_ff == ST_CHECK && action_ff == ACTION_MARK && in_grid);
   assign ram_wdata = (state_ff != ST_CLEAR);

   lgm_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .phase   (phase),
      .done    (cordic_done),
      .cos_out (cos_val),
      .sin_out (sin_val)
   );

   lgm_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .start    (cordic_done),
      .cos_in   (cos_val),
      .sin_in   (sin_val),
      .distance (dist_ff),
      .pose_x   (pose_x_ff),
      .pose_y   (pose_y_ff),
      .gains    (gains),
      .done     (scale_done),
      .coord_x  (coord_x),
      .coord_y  (coord_y)
   );

   lgm_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_grid_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         range_gain_ff <= RANGE_GAIN_RESET;
         pose_gain_ff <= POSE_GAIN_RESET;
         grid_width_ff <= GRID_SIZE_RESET;
         grid_height_ff <= GRID_SIZE_RESET;
         min_range_ff <= MIN_RANGE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RANGE_GAIN:  range_gain_ff <= csr_data[GAIN_W-1:0];
            CSR_POSE_GAIN:   pose_gain_ff <= csr_data[GAIN_W-1:0];
            CSR_GRID_WIDTH:  grid_width_ff <= csr_data[SIZE_W-1:0];
            CSR_GRID_HEIGHT: grid_height_ff <= csr_data[SIZE_W-1:0];
            CSR_MIN_RANGE:   min_range_ff <= csr_data[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == AW'(DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  last_ff <= req_last_point;
                  action_ff <= req_action;
                  dist_ff <= req_scan_distance;
                  pose_x_ff <= req_pose_x;
                  pose_y_ff <= req_pose_y;
                  if (req_action == ACTION_READ) begin
                     col_ff <= COORD_W'(req_query_col);
                     row_ff <= COORD_W'(req_query_row);
                     state_ff <= ST_CHECK;
                  end else if (req_scan_distance < min_range_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_marked_ff <= 1'b0;
                     rsp_col_ff <= '0;
                     rsp_row_ff <= '0;
                     rsp_status_ff <= STATUS_SKIPPED;
                     rsp_occupied_ff <= 1'b0;
                     rsp_last_ff <= req_last_point;
                  end else begin
                     state_ff <= ST_CALC;
                  end
               end
            end
            ST_CALC: begin
               if (scale_done) begin
                  col_ff <= coord_x;
                  row_ff <= coord_y;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               rsp_col_ff <= col_ff[7:0];
               rsp_row_ff <= row_ff[7:0];
               rsp_occupied_ff <= 1'b0;
               rsp_last_ff <= last_ff;
               if (!in_grid) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_marked_ff <= 1'b0;
                  rsp_status_ff <= STATUS_OUTSIDE;
                  state_ff <= ST_IDLE;
               end else if (action_ff == ACTION_READ) begin
                  state_ff <= ST_READ_WAIT;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  rsp_marked_ff <= 1'b1;
                  rsp_status_ff <= STATUS_OK;
                  state_ff <= ST_IDLE;
               end
            end
            ST_READ_WAIT: begin
               rsp_valid_ff <= 1'b1;
               rsp_marked_ff <= 1'b0;
               rsp_status_ff <= STATUS_OK;
               rsp_occupied_ff <= ram_rdata;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_marked = rsp_marked_ff;
   assign rsp_cell_col = rsp_col_ff;
   assign rsp_cell_row = rsp_row_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_occupied = rsp_occupied_ff;
   assign rsp_last_of_scan = rsp_last_ff;

`ifndef SYNTHESIS
   a_short_range_answers: assert property (@(posedge clock) disable iff (reset)
      accept && req_action == ACTION_MARK && req_scan_distance < min_range_ff
      |=> rsp_valid && rsp_status == STATUS_SKIPPED)
      else $error("short-range mark did not answer in the next cycle");

   a_marked_is_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_marked |-> rsp_status == STATUS_OK && !rsp_occupied)
      else $error("marked beat carries a wrong status or occupancy");

   a_read_ok_after_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK && !rsp_marked |-> $past(state_ff == ST_READ_WAIT))
      else $error("read beat issued without a memory read");

   a_no_result_while_clearing: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |=> !rsp_valid)
      else $error("result beat during the clearing pass");
`endif

endmodule
